// ===== design/swq_pkg.sv =====
// Shared types and codes for the semaphore wait queue table.
// Used by swq_scan and semaphore_wait_queue_table; depends on nothing.
`default_nettype none

package swq_pkg;

	// Operation carried by one input transfer.
	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_OUT    = 2'd2,
		MODE_PEEK   = 2'd3
	} mode_t;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_FREE   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// Status of the descriptor key search, reported to the sequencer.
	typedef struct packed {
		logic done;
		logic hit;
		logic free_found;
	} scan_flags_t;

endpackage

`default_nettype wire

// ===== design/swq_scan.sv =====
// Descriptor key search: while en is high, walks the key memory one entry
// a cycle through a single 32-bit comparator, noting the lowest free one.
// Depends on swq_pkg; the key memory itself lives in the top level.
`default_nettype none

module swq_scan
	import swq_pkg::*;
#(
	parameter int MAX_PROCS = 32,
	localparam int IW = $clog2(MAX_PROCS)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 en,
	input  wire logic [31:0]          key,
	input  wire logic [31:0]          rd_data,
	input  wire logic [MAX_PROCS-1:0] active,
	output logic      [IW-1:0]        rd_addr,
	output scan_flags_t               flags,
	output logic      [IW-1:0]        hit_idx,
	output logic      [IW-1:0]        free_idx
);

	localparam int CW = $clog2(MAX_PROCS + 1);

	logic [CW-1:0] cnt_q;
	logic          chk_valid_s1;
	logic [IW-1:0] chk_idx_s1;
	logic          free_found_q;
	logic [IW-1:0] free_idx_q;
	logic          all_issued;
	logic          take_free;

	// The read address leads the compare by the memory's registered read.
	assign rd_addr    = cnt_q[IW-1:0];
	assign all_issued = (cnt_q == CW'(MAX_PROCS));
	assign take_free  = chk_valid_s1 && !active[chk_idx_s1] && !free_found_q;

	// Compare the returned key against the search key.
	always_comb begin
		flags.hit        = chk_valid_s1 && active[chk_idx_s1] && (rd_data == key);
		flags.done       = flags.hit || (!chk_valid_s1 && all_issued);
		flags.free_found = free_found_q;
	end

	assign hit_idx  = chk_idx_s1;
	assign free_idx = free_idx_q;

	// Search control: address counter and compare valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			chk_valid_s1 <= 1'b0;
			free_found_q <= 1'b0;
		end else if (start) begin
			cnt_q        <= '0;
			chk_valid_s1 <= 1'b0;
			free_found_q <= 1'b0;
		end else if (en) begin
			if (!all_issued) begin
				chk_valid_s1 <= 1'b1;
				cnt_q        <= cnt_q + 1'b1;
			end else begin
				chk_valid_s1 <= 1'b0;
			end
			if (take_free) begin
				free_found_q <= 1'b1;
			end
		end
	end

	// Index of the entry under compare, and the first inactive one seen.
	always_ff @(posedge clk) begin
		if (en) begin
			chk_idx_s1 <= cnt_q[IW-1:0];
			if (take_free) begin
				free_idx_q <= chk_idx_s1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/semaphore_wait_queue_table.sv =====
// Semaphore wait queue table: descriptor pool with linked wait queues.
// Depends on swq_pkg and swq_scan.
//
// Usage: each input transfer (mode, sem_key, proc_id) is one request and
// gives exactly one result transfer (status, proc_out). Insert blocks a
// process on a key, remove takes the head of a key's queue, out takes a
// given process from its queue, and peek reads the head.
// The block handles one request at a time: in_stall is high from the
// transfer until the result is placed in the output register. The search
// for a key passes the descriptor key memory one entry a cycle through
// one comparator and stops at the first hit, so insert, remove and peek
// finish sooner when the key sits low in the pool. Out first reads the
// key the process waits on, then walks its queue through the next-pointer
// memory, passing states S_WALK and S_WALK_CHK for each entry passed.
// The result is held in an output register; a new request is taken while
// it waits, and a stalled result simply holds until out_stall falls, the
// next result waiting in the sequencer meanwhile.
// Reset clears all active and blocked flags at once; no clearing pass.
`default_nettype none

module semaphore_wait_queue_table
	import swq_pkg::*;
#(
	parameter int MAX_PROCS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [31:0] sem_key,
	input  wire logic [4:0]  proc_id,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [1:0]  status,
	output logic      [4:0]  proc_out
);

	localparam int IW = $clog2(MAX_PROCS);

	typedef enum logic [3:0] {
		S_IDLE,
		S_WKEY,
		S_WLOAD,
		S_SCAN,
		S_HRD,
		S_DESC,
		S_INS_NEW,
		S_APPEND,
		S_POP,
		S_POP_WR,
		S_WALK,
		S_WALK_CHK,
		S_UNLINK,
		S_FIN
	} state_t;

	state_t               state_q;
	mode_t                mode_q;
	logic [31:0]          key_q;
	logic [IW-1:0]        pid_ix_q;
	logic [IW-1:0]        d_q;
	logic [IW-1:0]        cur_q;
	logic [IW-1:0]        tail_q;
	logic [1:0]           res_status_q;
	logic [4:0]           res_pout_q;
	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [4:0]           proc_out_q;
	logic [MAX_PROCS-1:0] desc_active_q;
	logic [MAX_PROCS-1:0] proc_blocked_q;

	// Storage for keys, queue pointers and wait keys.
	logic [31:0]   desc_key_q      [MAX_PROCS];
	logic [IW-1:0] desc_head_q     [MAX_PROCS];
	logic [IW-1:0] desc_tail_q     [MAX_PROCS];
	logic [IW-1:0] proc_next_q     [MAX_PROCS];
	logic [31:0]   proc_wait_key_q [MAX_PROCS];

	logic [31:0]   key_rd_q;
	logic [IW-1:0] head_rd_q;
	logic [IW-1:0] tail_rd_q;
	logic [IW-1:0] nx_rd_q;
	logic [31:0]   wk_rd_q;

	logic          key_we, head_we, tail_we, nx_we, wk_we;
	logic [IW-1:0] key_wa, head_wa, tail_wa, nx_wa, wk_wa;
	logic [IW-1:0] head_wd, tail_wd, nx_wd;
	logic [IW-1:0] key_ra, nx_ra;

	logic          in_xfer;
	logic          pid_ok;
	logic [IW-1:0] pid_in_ix;
	mode_t         mode_in;
	logic          out_free;

	scan_flags_t   scan_flags;
	logic [IW-1:0] scan_hit_idx;
	logic [IW-1:0] scan_free_idx;
	logic          scan_start;
	logic          scan_en;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign pid_ok    = (32'(proc_id) < 32'(MAX_PROCS));
	assign pid_in_ix = IW'(proc_id);
	assign mode_in   = mode_t'(mode);
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign proc_out  = proc_out_q;

	assign scan_start = in_xfer || (state_q == S_WLOAD);
	assign scan_en    = (state_q == S_SCAN);

	// Key search over the descriptor pool.
	swq_scan #(
		.MAX_PROCS(MAX_PROCS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scan_start),
		.en       (scan_en),
		.key      (key_q),
		.rd_data  (key_rd_q),
		.active   (desc_active_q),
		.rd_addr  (key_ra),
		.flags    (scan_flags),
		.hit_idx  (scan_hit_idx),
		.free_idx (scan_free_idx)
	);

	// Next-pointer read: the walk reads the cursor, the unlink reads the
	// entry that follows the process being taken out.
	assign nx_ra = (state_q == S_WALK_CHK) ? pid_ix_q : cur_q;

	// Memory write controls, one write per memory in each cycle.
	always_comb begin
		key_we  = 1'b0;
		head_we = 1'b0;
		tail_we = 1'b0;
		nx_we   = 1'b0;
		wk_we   = 1'b0;
		key_wa  = scan_free_idx;
		head_wa = d_q;
		tail_wa = d_q;
		nx_wa   = pid_ix_q;
		wk_wa   = pid_ix_q;
		head_wd = pid_ix_q;
		tail_wd = pid_ix_q;
		nx_wd   = pid_ix_q;
		unique case (state_q)
			S_INS_NEW: begin
				key_we  = 1'b1;
				head_we = 1'b1;
				head_wa = scan_free_idx;
				tail_we = 1'b1;
				tail_wa = scan_free_idx;
				nx_we   = 1'b1;
				wk_we   = 1'b1;
			end
			S_DESC: begin
				if (mode_q == MODE_INSERT) begin
					nx_we   = 1'b1;
					nx_wa   = tail_rd_q;
					tail_we = 1'b1;
					wk_we   = 1'b1;
				end
			end
			S_APPEND: begin
				nx_we = 1'b1;
			end
			S_POP_WR: begin
				head_we = 1'b1;
				head_wd = nx_rd_q;
			end
			S_WALK_CHK: begin
				if (nx_rd_q == pid_ix_q && tail_q == pid_ix_q) begin
					tail_we = 1'b1;
					tail_wd = cur_q;
					nx_we   = 1'b1;
					nx_wa   = cur_q;
					nx_wd   = cur_q;
				end
			end
			S_UNLINK: begin
				nx_we = 1'b1;
				nx_wa = cur_q;
				nx_wd = nx_rd_q;
			end
			default: begin
			end
		endcase
	end

	// Descriptor key memory.
	always_ff @(posedge clk) begin
		if (key_we) begin
			desc_key_q[key_wa] <= key_q;
		end
		key_rd_q <= desc_key_q[key_ra];
	end

	// Queue head memory.
	always_ff @(posedge clk) begin
		if (head_we) begin
			desc_head_q[head_wa] <= head_wd;
		end
		head_rd_q <= desc_head_q[d_q];
	end

	// Queue tail memory.
	always_ff @(posedge clk) begin
		if (tail_we) begin
			desc_tail_q[tail_wa] <= tail_wd;
		end
		tail_rd_q <= desc_tail_q[d_q];
	end

	// Next-pointer memory linking blocked processes.
	always_ff @(posedge clk) begin
		if (nx_we) begin
			proc_next_q[nx_wa] <= nx_wd;
		end
		nx_rd_q <= proc_next_q[nx_ra];
	end

	// Key that each blocked process waits on.
	always_ff @(posedge clk) begin
		if (wk_we) begin
			proc_wait_key_q[wk_wa] <= key_q;
		end
		wk_rd_q <= proc_wait_key_q[pid_ix_q];
	end

	// Sequencer, flags and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			mode_q         <= MODE_INSERT;
			key_q          <= '0;
			pid_ix_q       <= '0;
			d_q            <= '0;
			cur_q          <= '0;
			tail_q         <= '0;
			res_status_q   <= ST_NOT_FOUND;
			res_pout_q     <= '0;
			out_valid_q    <= 1'b0;
			status_q       <= ST_NOT_FOUND;
			proc_out_q     <= '0;
			desc_active_q  <= '0;
			proc_blocked_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						mode_q       <= mode_in;
						key_q        <= sem_key;
						pid_ix_q     <= pid_in_ix;
						res_status_q <= ST_NOT_FOUND;
						res_pout_q   <= '0;
						unique case (mode_in)
							MODE_INSERT: begin
								if (pid_ok && !proc_blocked_q[pid_in_ix]) begin
									state_q <= S_SCAN;
								end else begin
									state_q <= S_FIN;
								end
							end
							MODE_OUT: begin
								if (pid_ok && proc_blocked_q[pid_in_ix]) begin
									state_q <= S_WKEY;
								end else begin
									state_q <= S_FIN;
								end
							end
							default: begin
								state_q <= S_SCAN;
							end
						endcase
					end
				end
				S_WKEY: begin
					state_q <= S_WLOAD;
				end
				S_WLOAD: begin
					key_q   <= wk_rd_q;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_flags.done) begin
						if (scan_flags.hit) begin
							d_q     <= scan_hit_idx;
							state_q <= S_HRD;
						end else if (mode_q == MODE_INSERT) begin
							if (scan_flags.free_found) begin
								state_q <= S_INS_NEW;
							end else begin
								res_status_q <= ST_NO_FREE;
								state_q      <= S_FIN;
							end
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_HRD: begin
					state_q <= S_DESC;
				end
				S_DESC: begin
					cur_q  <= head_rd_q;
					tail_q <= tail_rd_q;
					unique case (mode_q)
						MODE_INSERT: begin
							proc_blocked_q[pid_ix_q] <= 1'b1;
							res_status_q             <= ST_OK;
							state_q                  <= S_APPEND;
						end
						MODE_PEEK: begin
							res_status_q <= ST_OK;
							res_pout_q   <= 5'(head_rd_q);
							state_q      <= S_FIN;
						end
						MODE_REMOVE: begin
							state_q <= S_POP;
						end
						default: begin
							if (head_rd_q == pid_ix_q) begin
								state_q <= S_POP;
							end else begin
								state_q <= S_WALK;
							end
						end
					endcase
				end
				S_INS_NEW: begin
					desc_active_q[scan_free_idx] <= 1'b1;
					proc_blocked_q[pid_ix_q]     <= 1'b1;
					res_status_q                 <= ST_OK;
					state_q                      <= S_FIN;
				end
				S_APPEND: begin
					state_q <= S_FIN;
				end
				S_POP: begin
					res_status_q <= ST_OK;
					res_pout_q   <= 5'(cur_q);
					if (cur_q == tail_q) begin
						// Last entry leaves: the descriptor goes back to the pool.
						desc_active_q[d_q]    <= 1'b0;
						proc_blocked_q[cur_q] <= 1'b0;
						state_q               <= S_FIN;
					end else begin
						state_q <= S_POP_WR;
					end
				end
				S_POP_WR: begin
					proc_blocked_q[cur_q] <= 1'b0;
					state_q               <= S_FIN;
				end
				S_WALK: begin
					if (cur_q == tail_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_WALK_CHK;
					end
				end
				S_WALK_CHK: begin
					if (nx_rd_q == pid_ix_q) begin
						if (tail_q == pid_ix_q) begin
							proc_blocked_q[pid_ix_q] <= 1'b0;
							res_status_q             <= ST_OK;
							res_pout_q               <= 5'(pid_ix_q);
							state_q                  <= S_FIN;
						end else begin
							state_q <= S_UNLINK;
						end
					end else begin
						cur_q   <= nx_rd_q;
						state_q <= S_WALK;
					end
				end
				S_UNLINK: begin
					proc_blocked_q[pid_ix_q] <= 1'b0;
					res_status_q             <= ST_OK;
					res_pout_q               <= 5'(pid_ix_q);
					state_q                  <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						proc_out_q  <= res_pout_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Every active descriptor holds at least one blocked process.
	a_active_le_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(desc_active_q) <= $countones(proc_blocked_q))
		else $error("more active descriptors than blocked processes");

	// A failed request never reports a process.
	a_fail_no_proc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (proc_out == 5'd0))
		else $error("process reported with a failing status");

	// Only defined status codes are produced.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_NO_FREE || status == ST_NOT_FOUND))
		else $error("undefined status code");

	// Once a request is taken, no further request is taken the next cycle.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request taken while another is in flight");

endmodule

`default_nettype wire

// ===== sim/semaphore_wait_queue_table_test.sv =====
// Self-checking testbench for semaphore_wait_queue_table: directed and random requests.
// Holds its own model of the descriptor pool and wait queues; depends on swq_pkg.
// Every result transfer is checked against the model's prediction.
`default_nettype none

module semaphore_wait_queue_table_test;
	import swq_pkg::*;

	localparam int PROCS = 32;
	localparam int RANDOM_REQUESTS = 1400;
	localparam int PHASE_LENGTH = 175;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 2 * PROCS + 48;

	typedef struct {
		mode_t       op;
		logic [31:0] key;
		logic [4:0]  pid;
	} request_t;

	typedef struct {
		logic [1:0] st;
		logic [4:0] pid;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	mode_t       req_mode = MODE_INSERT;
	logic [31:0] req_key = '0;
	logic [4:0]  req_pid = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [4:0]  proc_out;

	semaphore_wait_queue_table #(
		.MAX_PROCS(PROCS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(req_mode),
		.sem_key(req_key),
		.proc_id(req_pid),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.proc_out(proc_out)
	);

	// Model of the table: descriptor slots and per-process links.
	bit   [PROCS-1:0] slot_live;
	logic [31:0]      slot_key [PROCS];
	logic [4:0]       slot_first [PROCS];
	logic [4:0]       slot_last [PROCS];
	logic [4:0]       link_next [PROCS];
	logic [31:0]      waits_on [PROCS];
	bit   [PROCS-1:0] blocked;

	request_t requests_pending [$];
	outcome_t results_due [$];
	int       requests_sent = 0;
	int       requests_taken = 0;
	int       cycle_count = 0;
	int       failures = 0;
	int       results_seen = 0;
	int       count_ok = 0;
	int       count_not_found = 0;
	int       count_no_free = 0;
	int       peak_live = 0;
	int       peak_blocked = 0;
	logic [31:0] key_pool [PROCS];
	int       pool_size = 3;

	// Random idling and output stalls are off in a calm window that recurs through the run.
	wire calm = (cycle_count % 20000) < 6000;

	function automatic int find_slot(logic [31:0] k);
		for (int d = 0; d < PROCS; d++)
			if (slot_live[d] && slot_key[d] == k)
				return d;
		return -1;
	endfunction

	function automatic int free_slot();
		for (int d = 0; d < PROCS; d++)
			if (!slot_live[d])
				return d;
		return -1;
	endfunction

	// Take the head of slot d's queue; the slot is freed when its queue empties.
	function automatic logic [4:0] take_first(int d);
		logic [4:0] h;
		h = slot_first[d];
		if (h == slot_last[d])
			slot_live[d] = 1'b0;
		else
			slot_first[d] = link_next[h];
		blocked[h] = 1'b0;
		return h;
	endfunction

	// Apply one request to the model and return the result it gives.
	function automatic outcome_t apply_semaphore_op(request_t r);
		outcome_t   res;
		int         d;
		logic [4:0] cur;
		logic [4:0] nx;
		bit         done;
		res.st = ST_NOT_FOUND;
		res.pid = '0;
		case (r.op)
			MODE_INSERT: begin
				if (!blocked[r.pid]) begin
					d = find_slot(r.key);
					if (d < 0) begin
						d = free_slot();
						if (d < 0) begin
							res.st = ST_NO_FREE;
						end else begin
							slot_live[d] = 1'b1;
							slot_key[d] = r.key;
							slot_first[d] = r.pid;
							slot_last[d] = r.pid;
							res.st = ST_OK;
						end
					end else begin
						link_next[slot_last[d]] = r.pid;
						slot_last[d] = r.pid;
						res.st = ST_OK;
					end
					if (res.st == ST_OK) begin
						blocked[r.pid] = 1'b1;
						waits_on[r.pid] = r.key;
						link_next[r.pid] = r.pid;
					end
				end
			end
			MODE_REMOVE, MODE_PEEK: begin
				d = find_slot(r.key);
				if (d >= 0) begin
					res.st = ST_OK;
					if (r.op == MODE_REMOVE)
						res.pid = take_first(d);
					else
						res.pid = slot_first[d];
				end
			end
			MODE_OUT: begin
				if (blocked[r.pid]) begin
					d = find_slot(waits_on[r.pid]);
					if (d >= 0) begin
						cur = slot_first[d];
						if (cur == r.pid) begin
							void'(take_first(d));
							res.st = ST_OK;
							res.pid = r.pid;
						end else begin
							// Walk the queue for the predecessor of the process.
							done = 1'b0;
							for (int n = 0; n < PROCS && !done; n++) begin
								nx = link_next[cur];
								if (cur == slot_last[d]) begin
									done = 1'b1;
								end else if (nx == r.pid) begin
									if (slot_last[d] == r.pid) begin
										slot_last[d] = cur;
										link_next[cur] = cur;
									end else begin
										link_next[cur] = link_next[r.pid];
									end
									blocked[r.pid] = 1'b0;
									res.st = ST_OK;
									res.pid = r.pid;
									done = 1'b1;
								end else begin
									cur = nx;
								end
							end
						end
					end
				end
			end
		endcase
		return res;
	endfunction

	// A process whose blocked flag matches the wish, or any one if none does.
	function automatic logic [4:0] pick_proc(bit want_blocked);
		int first;
		int p;
		first = $urandom_range(0, PROCS - 1);
		for (int i = 0; i < PROCS; i++) begin
			p = (first + i) % PROCS;
			if (blocked[p] == want_blocked)
				return p[4:0];
		end
		return 5'($urandom_range(0, PROCS - 1));
	endfunction

	function automatic logic [31:0] pool_key();
		return key_pool[$urandom_range(0, pool_size - 1)];
	endfunction

	// The key of a live descriptor, or a pool key when none is live.
	function automatic logic [31:0] live_key();
		int first;
		int d;
		first = $urandom_range(0, PROCS - 1);
		for (int i = 0; i < PROCS; i++) begin
			d = (first + i) % PROCS;
			if (slot_live[d])
				return slot_key[d];
		end
		return pool_key();
	endfunction

	// Clock generation.
	always #10 clk = ~clk;

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Requests and out_stall: a new transfer is offered once the previous one is taken.
	always @(negedge clk) begin
		request_t r;
		if (arst_n) begin
			if (requests_sent == requests_taken) begin
				if (requests_pending.size() > 0 && (calm || $urandom_range(0, 99) >= 6)) begin
					r = requests_pending.pop_front();
					req_mode <= r.op;
					req_key <= r.key;
					req_pid <= r.pid;
					in_valid <= 1'b1;
					requests_sent <= requests_sent + 1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= !calm && $urandom_range(0, 99) < 6;
		end
	end

	// Monitor: predict on each request transfer, check each result transfer.
	always @(posedge clk) begin
		request_t taken_req;
		outcome_t due;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				taken_req.op = req_mode;
				taken_req.key = req_key;
				taken_req.pid = req_pid;
				results_due.push_back(apply_semaphore_op(taken_req));
				requests_taken <= requests_taken + 1;
				if ($countones(slot_live) > peak_live)
					peak_live = $countones(slot_live);
				if ($countones(blocked) > peak_blocked)
					peak_blocked = $countones(blocked);
			end
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$error("result with nothing outstanding: status %0d proc_out %0d",
						status, proc_out);
					failures++;
				end else begin
					due = results_due.pop_front();
					results_seen++;
					if (status !== due.st) begin
						$error("status: expected %0d, got %0d", due.st, status);
						failures++;
					end
					if (proc_out !== due.pid) begin
						$error("proc_out: expected %0d, got %0d", due.pid, proc_out);
						failures++;
					end
					case (due.st)
						ST_OK:      count_ok++;
						ST_NO_FREE: count_no_free++;
						default:    count_not_found++;
					endcase
				end
			end
		end
	end

	// Stimulus: reset, a directed sequence, then random requests.
	initial begin
		request_t r;
		int roll;
		int insert_pct;
		int phase;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty table, then a queue of four processes on key zero.
		requests_pending.push_back('{MODE_PEEK, 32'h0000_0000, 5'd0});
		requests_pending.push_back('{MODE_REMOVE, 32'hFFFF_FFFF, 5'd31});
		requests_pending.push_back('{MODE_OUT, 32'h1234_5678, 5'd31});
		requests_pending.push_back('{MODE_INSERT, 32'h0000_0000, 5'd0});
		requests_pending.push_back('{MODE_INSERT, 32'h0000_0000, 5'd31});
		requests_pending.push_back('{MODE_INSERT, 32'h0000_0000, 5'd7});
		requests_pending.push_back('{MODE_INSERT, 32'h0000_0000, 5'd12});
		// Process already blocked, on its own key and on another; then middle, tail and head outs.
		requests_pending.push_back('{MODE_INSERT, 32'h0000_0000, 5'd0});
		requests_pending.push_back('{MODE_INSERT, 32'hFFFF_FFFF, 5'd31});
		requests_pending.push_back('{MODE_INSERT, 32'hFFFF_FFFF, 5'd5});
		requests_pending.push_back('{MODE_PEEK, 32'h0000_0000, 5'd0});
		requests_pending.push_back('{MODE_OUT, 32'hFFFF_FFFF, 5'd7});
		requests_pending.push_back('{MODE_OUT, 32'h0000_0000, 5'd12});
		requests_pending.push_back('{MODE_INSERT, 32'h0000_0000, 5'd9});
		requests_pending.push_back('{MODE_REMOVE, 32'h0000_0000, 5'd0});
		requests_pending.push_back('{MODE_OUT, 32'h0000_0000, 5'd31});
		requests_pending.push_back('{MODE_PEEK, 32'h0000_0000, 5'd31});
		requests_pending.push_back('{MODE_REMOVE, 32'h0000_0000, 5'd0});
		requests_pending.push_back('{MODE_PEEK, 32'h0000_0000, 5'd0});
		requests_pending.push_back('{MODE_INSERT, 32'hA5A5_5A5A, 5'd20});
		// Last process of a queue leaves by out, freeing its descriptor.
		requests_pending.push_back('{MODE_OUT, 32'h0000_0000, 5'd5});
		requests_pending.push_back('{MODE_PEEK, 32'hFFFF_FFFF, 5'd0});
		requests_pending.push_back('{MODE_REMOVE, 32'hA5A5_5A5A, 5'd20});
		requests_pending.push_back('{MODE_OUT, 32'hA5A5_5A5A, 5'd20});

		// Random part: phases alternate between few shared keys and many keys.
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i % PHASE_LENGTH == 0) begin
				phase = i / PHASE_LENGTH;
				pool_size = (phase % 2) ? PROCS : 3;
				for (int j = 0; j < PROCS; j++)
					key_pool[j] = $urandom;
				if ($urandom_range(0, 1))
					key_pool[0] = 32'h0000_0000;
				if ($urandom_range(0, 1))
					key_pool[1] = 32'hFFFF_FFFF;
			end
			while (requests_pending.size() >= 2)
				@(posedge clk);

			// Keep roughly half the processes blocked so queues stay deep.
			if ($countones(blocked) < 8)
				insert_pct = 65;
			else if ($countones(blocked) > 24)
				insert_pct = 20;
			else
				insert_pct = 40;
			r.key = $urandom;
			r.pid = 5'($urandom_range(0, PROCS - 1));
			roll = $urandom_range(0, 99);
			if (roll < insert_pct) begin
				r.op = MODE_INSERT;
				if ($urandom_range(0, 99) < 88)
					r.pid = pick_proc(1'b0);
				if ($urandom_range(0, 9) != 0)
					r.key = pool_key();
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 35) begin
					r.op = MODE_OUT;
					if ($urandom_range(0, 99) < 85)
						r.pid = pick_proc(1'b1);
				end else begin
					r.op = (roll < 70) ? MODE_REMOVE : MODE_PEEK;
					r.key = ($urandom_range(0, 99) < 80) ? live_key() : pool_key();
				end
			end
			requests_pending.push_back(r);
		end

		// Drain: wait for every result, then a quiet spell for stray transfers.
		while (requests_pending.size() != 0 || requests_sent != requests_taken
				|| results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results: %0d ok, %0d not found, %0d with no free descriptor.",
			results_seen, count_ok, count_not_found, count_no_free);
		$display("At most %0d descriptors were live and %0d processes blocked at once.",
			peak_live, peak_blocked);
		if (failures == 0 && results_due.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire
